/* hw/rtl/ntis_pkg.sv */
// ----------------------------------------------------------------------------
// ntis_pkg
// Shared types and constants for the name table (create, delete, search,
// traverse over a packed table of unique 72-bit name keys).
// ----------------------------------------------------------------------------
package ntis_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int KEY_W           = 72;
    localparam int POS_W           = 4;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

    typedef logic [KEY_W-1:0] name_key_t;

    typedef enum logic [1:0] {
        MODE_CREATE   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRAVERSE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] name_low;
        logic [7:0]  name_high;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [63:0]      entry_low;
        logic [7:0]       entry_high;
        logic             last;
    } rsp_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_SHIFT,
        SEQ_LIST,
        SEQ_REPORT
    } seq_state_t;

endpackage

/* hw/rtl/name_table_insert_delete_search.sv */
// ----------------------------------------------------------------------------
// name_table_insert_delete_search
// Packed table of unique 72-bit names with create, delete, search and
// traverse commands, plus a capacity limit register.
// ----------------------------------------------------------------------------
// The table sits in a single-port-read memory that the sequencer walks one
// entry per cycle, except while a traverse result waits on rsp_ready. One
// request is in flight at a time; req_ready is high only while the
// sequencer is idle. Search and create compare the stored entries in order
// and stop early on a match; create reports full without a walk. Delete
// walks up to the match, then shifts the later entries down. Traverse returns
// one result per cycle while the response register can take it, up to 16.
// The response register lets the next request be taken while a result still
// waits on rsp_ready. Capacity resets to 10; values above ENTRIES act as
// ENTRIES. Lowering it below the current count keeps the stored names and
// makes create report full. Write the capacity only while no request is
// outstanding.
// ----------------------------------------------------------------------------
module name_table_insert_delete_search #(
    parameter int ENTRIES = ntis_pkg::ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ntis_pkg::CAP_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ntis_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output ntis_pkg::rsp_t             rsp
);
    import ntis_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [CAP_W-1:0] capacity_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic          res_valid, res_ready;
    rsp_t          res;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    name_key_t     mem_wdata, mem_rdata;

    // Capacity register: always ready, take each transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    ntis_mem #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ntis_seq #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Response register: load a new result when empty or being drained,
    // otherwise hold it and stall the sequencer.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hw/rtl/ntis_mem.sv */
// ----------------------------------------------------------------------------
// ntis_mem
// Name key storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ntis_mem #(
    parameter int DEPTH = ntis_pkg::ENTRIES_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ntis_pkg::name_key_t wdata,
    input  logic [AW-1:0]       raddr,
    output ntis_pkg::name_key_t rdata
);
    import ntis_pkg::*;

    name_key_t mem [DEPTH];
    name_key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ntis_seq.sv */
// ----------------------------------------------------------------------------
// ntis_seq
// Sequencer: walks the table through the single read port to compare,
// shift down after a delete, or list entries; owns the entry count.
// ----------------------------------------------------------------------------
module ntis_seq #(
    parameter int ENTRIES = ntis_pkg::ENTRIES_DEFAULT,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ntis_pkg::CAP_W-1:0] capacity,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ntis_pkg::req_t             req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output ntis_pkg::rsp_t             res,
    output logic                       mem_we,
    output logic [IW-1:0]              mem_waddr,
    output ntis_pkg::name_key_t        mem_wdata,
    output logic [IW-1:0]              mem_raddr,
    input  ntis_pkg::name_key_t        mem_rdata
);
    import ntis_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = CW + 1;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int TRAV_MAX = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
    localparam logic [CW-1:0] TRAV_MAX_C = CW'(TRAV_MAX);
    localparam logic [CW-1:0] ENTRIES_C  = CW'(ENTRIES);

    seq_state_t       state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    mode_t            mode_reg, mode_next;
    name_key_t        key_reg, key_next;
    status_t          status_reg, status_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [SW-1:0] idx_ext, cnt_ext, sum1, sum2;
    logic [CW-1:0] trav_n;
    logic          full, hit, scan_end, list_last;
    name_key_t     req_key;

    assign req_key  = {req.name_high, req.name_low};
    assign idx_ext  = SW'(idx_reg);
    assign cnt_ext  = SW'(count_reg);
    assign sum1     = idx_ext + SW'(1);
    assign sum2     = idx_ext + SW'(2);
    assign full     = (LW'(count_reg) >= LW'(capacity)) || (count_reg == ENTRIES_C);
    assign hit      = (idx_ext < cnt_ext) && (mem_rdata == key_reg);
    assign scan_end = (sum1 >= cnt_ext);
    assign trav_n   = (count_reg < TRAV_MAX_C) ? count_reg : TRAV_MAX_C;
    assign list_last = (sum1 == SW'(trav_n));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pos_next    = pos_reg;

        req_ready = 1'b0;
        res_valid = 1'b0;
        res       = '{status: ST_OK, position: '0, entry_low: '0,
                      entry_high: '0, last: 1'b1};
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_raddr = '0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                // Entry 0 is always being fetched here, so a scan or list
                // sees it in the cycle after the transfer.
                req_ready = 1'b1;
                mem_raddr = '0;
                if (req_valid)
                begin
                    mode_next = req.mode;
                    key_next  = req_key;
                    idx_next  = '0;
                    pos_next  = '0;
                    unique case (req.mode)
                        MODE_CREATE:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = SEQ_REPORT;
                            end
                            else
                            begin
                                state_next = SEQ_SCAN;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = SEQ_REPORT;
                            end
                            else
                            begin
                                state_next = SEQ_SCAN;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            state_next = SEQ_SCAN;
                        end
                        MODE_TRAVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = SEQ_REPORT;
                            end
                            else
                            begin
                                state_next = SEQ_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = SEQ_IDLE;
                        end
                    endcase
                end
            end

            SEQ_SCAN:
            begin
                // Compare entry idx while the next one is fetched.
                mem_raddr = sum1[IW-1:0];
                if (hit)
                begin
                    pos_next = POS_W'(idx_reg);
                    priority case (mode_reg)
                        MODE_CREATE:
                        begin
                            status_next = ST_DUP;
                            state_next  = SEQ_REPORT;
                        end
                        MODE_DELETE:
                        begin
                            status_next = ST_OK;
                            if (sum1 < cnt_ext)
                            begin
                                state_next = SEQ_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = SEQ_REPORT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                            state_next  = SEQ_REPORT;
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    state_next = SEQ_REPORT;
                    if (mode_reg == MODE_CREATE)
                    begin
                        // Append at the end of the packed table.
                        mem_we      = 1'b1;
                        mem_waddr   = count_reg[IW-1:0];
                        mem_wdata   = key_reg;
                        status_next = ST_OK;
                        pos_next    = POS_W'(count_reg);
                        count_next  = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                        pos_next    = '0;
                    end
                end
                else
                begin
                    idx_next = sum1[IW-1:0];
                end
            end

            SEQ_SHIFT:
            begin
                // Move entry idx+1 down into idx; fetch idx+2 meanwhile.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = sum2[IW-1:0];
                if (sum2 < cnt_ext)
                begin
                    idx_next = sum1[IW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = SEQ_REPORT;
                end
            end

            SEQ_LIST:
            begin
                res_valid      = 1'b1;
                res.status     = ST_OK;
                res.position   = POS_W'(idx_reg);
                res.entry_low  = mem_rdata[63:0];
                res.entry_high = mem_rdata[KEY_W-1:64];
                res.last       = list_last;
                mem_raddr      = res_ready ? sum1[IW-1:0] : idx_reg;
                if (res_ready)
                begin
                    if (list_last)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        idx_next = sum1[IW-1:0];
                    end
                end
            end

            SEQ_REPORT:
            begin
                res_valid    = 1'b1;
                res.status   = status_reg;
                res.position = pos_reg;
                res.last     = 1'b1;
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule
